### rtl/core/ibck_pkg.sv
// Shared types, codes and constants of the color-keyed blit block.
package ibck_pkg;

	localparam int unsigned DISPLAY_COLS = 320;
	localparam int unsigned DISPLAY_ROWS = 240;

	localparam int unsigned COL_W = 9;
	localparam int unsigned ROW_W = 8;
	localparam int unsigned PIX_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [PIX_W-1:0] KEY_RESET = 16'hF81F;

	// Input actions
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_IDLE  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEST_COL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_ROW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_W    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_H    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY      = 3'd4;

	typedef struct packed {
		logic [COL_W-1:0] dest_col;
		logic [ROW_W-1:0] dest_row;
		logic [COL_W-1:0] img_w;
		logic [ROW_W-1:0] img_h;
		logic [PIX_W-1:0] key;
	} cfg_t;

	// Classified word passed from the front to the back
	typedef struct packed {
		logic [1:0]       status;
		logic             active;
		logic [COL_W-1:0] src_x;
		logic [ROW_W-1:0] src_y;
		logic [PIX_W-1:0] pixel;
		logic             done;
	} job_t;

endpackage

### rtl/core/ibck_front.sv
// Front end: accepts words, runs the bounds check and the raster counters.
module ibck_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ibck_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [ibck_pkg::PIX_W-1:0]  pixel,
	input  logic                        q_full,
	output logic                        q_push,
	output ibck_pkg::job_t              q_word
);

	logic                          armed_q;
	logic [ibck_pkg::COL_W-1:0]    src_x_q;
	logic [ibck_pkg::ROW_W-1:0]    src_y_q;
	logic [ibck_pkg::COL_W:0]      col_sum;
	logic [ibck_pkg::ROW_W:0]      row_sum;
	logic                          outside;
	logic                          row_end;
	logic                          last_row;
	logic                          accept;

	assign col_sum = {1'b0, cfg.dest_col} + {1'b0, cfg.img_w};
	assign row_sum = {1'b0, cfg.dest_row} + {1'b0, cfg.img_h};
	assign outside = (col_sum > (ibck_pkg::COL_W+1)'(ibck_pkg::DISPLAY_COLS)) ||
		(row_sum > (ibck_pkg::ROW_W+1)'(ibck_pkg::DISPLAY_ROWS));
	assign row_end  = ({1'b0, src_x_q} + 1'b1) >= {1'b0, cfg.img_w};
	assign last_row = ({1'b0, src_y_q} + 1'b1) >= {1'b0, cfg.img_h};

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	always_comb begin
		q_word        = '0;
		q_word.status = ibck_pkg::ST_OK;
		if (action == ibck_pkg::ACT_START) begin
			q_word.status = outside ? ibck_pkg::ST_RANGE : ibck_pkg::ST_OK;
		end else if (!armed_q) begin
			q_word.status = ibck_pkg::ST_IDLE;
		end else begin
			q_word.active = 1'b1;
			q_word.src_x  = src_x_q;
			q_word.src_y  = src_y_q;
			q_word.pixel  = pixel;
			q_word.done   = row_end && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			src_x_q <= '0;
			src_y_q <= '0;
		end else if (accept) begin
			if (action == ibck_pkg::ACT_START) begin
				src_x_q <= '0;
				src_y_q <= '0;
				armed_q <= !outside && (cfg.img_w != '0) && (cfg.img_h != '0);
			end else if (armed_q) begin
				if (row_end) begin
					src_x_q <= '0;
					if (last_row) begin
						src_y_q <= '0;
						armed_q <= 1'b0;
					end else begin
						src_y_q <= src_y_q + 1'b1;
					end
				end else begin
					src_x_q <= src_x_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/core/ibck_fifo.sv
// Two-entry queue of classified words between front and back.
module ibck_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ibck_pkg::job_t  push_word,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output ibck_pkg::job_t  pop_word
);

	ibck_pkg::job_t  slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_word = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/ibck_back.sv
// Back end: key compare, display coordinates and the output register.
module ibck_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ibck_pkg::cfg_t              cfg,
	input  logic                        q_empty,
	input  ibck_pkg::job_t              q_word,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic                        write_enable,
	output logic [ibck_pkg::COL_W-1:0]  disp_x,
	output logic [ibck_pkg::ROW_W-1:0]  disp_y,
	output logic [ibck_pkg::PIX_W-1:0]  pixel_out,
	output logic                        frame_done
);

	logic                        valid_q;
	logic [1:0]                  status_q;
	logic                        we_q;
	logic [ibck_pkg::COL_W-1:0]  x_q;
	logic [ibck_pkg::ROW_W-1:0]  y_q;
	logic [ibck_pkg::PIX_W-1:0]  pix_q;
	logic                        done_q;

	// Advance whenever the output register is free or being drained
	assign q_pop = !q_empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_q <= q_word.status;
			if (q_word.active) begin
				we_q   <= (q_word.pixel != cfg.key);
				x_q    <= cfg.dest_col + q_word.src_x;
				y_q    <= cfg.dest_row + q_word.src_y;
				pix_q  <= q_word.pixel;
				done_q <= q_word.done;
			end else begin
				we_q   <= 1'b0;
				x_q    <= '0;
				y_q    <= '0;
				pix_q  <= '0;
				done_q <= 1'b0;
			end
		end
	end

	assign out_valid    = valid_q;
	assign status       = status_q;
	assign write_enable = we_q;
	assign disp_x       = x_q;
	assign disp_y       = y_q;
	assign pixel_out    = pix_q;
	assign frame_done   = done_q;

endmodule

### rtl/core/image_blit_color_key_top.sv
// Top level of the color-keyed transparent RGB565 blit block.
//
//  channel  handshake              payload
//  -------  ---------------------  ----------------------------------------------
//  in       in_valid / in_ready    action, pixel
//  out      out_valid / out_ready  status, write_enable, disp_x, disp_y,
//                                  pixel_out, frame_done
//  cfg      cfg_we (no wait)       cfg_addr, cfg_wdata
//
// One word per cycle sustained while the output is not stalled. An accepted word
// is written into the queue, then taken into the output register: the front
// classifies it and updates the raster counters in the cycle of acceptance, the
// back takes it from the queue next. Reset clears the armed flag, the counters,
// the queue and the output valid. A stalled output backs the two-entry queue up;
// in_ready drops only when the queue is full. Under a steady stream one entry is
// already held, so an output stall fills the queue and holds off the input.
module image_blit_color_key_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [ibck_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [ibck_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// input word channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [ibck_pkg::PIX_W-1:0]        pixel,
	// result word channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic                              write_enable,
	output logic [ibck_pkg::COL_W-1:0]        disp_x,
	output logic [ibck_pkg::ROW_W-1:0]        disp_y,
	output logic [ibck_pkg::PIX_W-1:0]        pixel_out,
	output logic                              frame_done
);

	ibck_pkg::cfg_t  cfg_q;
	ibck_pkg::job_t  push_word;
	ibck_pkg::job_t  pop_word;
	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;

	// Configuration registers; writes to unused indexes drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_col <= '0;
			cfg_q.dest_row <= '0;
			cfg_q.img_w    <= ibck_pkg::COL_W'(1);
			cfg_q.img_h    <= ibck_pkg::ROW_W'(1);
			cfg_q.key      <= ibck_pkg::KEY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ibck_pkg::REG_DEST_COL: cfg_q.dest_col <= cfg_wdata[ibck_pkg::COL_W-1:0];
				ibck_pkg::REG_DEST_ROW: cfg_q.dest_row <= cfg_wdata[ibck_pkg::ROW_W-1:0];
				ibck_pkg::REG_IMG_W:    cfg_q.img_w    <= cfg_wdata[ibck_pkg::COL_W-1:0];
				ibck_pkg::REG_IMG_H:    cfg_q.img_h    <= cfg_wdata[ibck_pkg::ROW_W-1:0];
				ibck_pkg::REG_KEY:      cfg_q.key      <= cfg_wdata[ibck_pkg::PIX_W-1:0];
				default:                cfg_q          <= cfg_q;
			endcase
		end
	end

	// Front: bounds check and arming on start, raster position on pixels
	ibck_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.pixel     (pixel),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_word    (push_word)
	);

	// Queue decoupling the two halves
	ibck_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_word  (pop_word)
	);

	// Back: key compare, coordinate add, output register
	ibck_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_word       (pop_word),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.write_enable (write_enable),
		.disp_x       (disp_x),
		.disp_y       (disp_y),
		.pixel_out    (pixel_out),
		.frame_done   (frame_done)
	);

endmodule
